>>> sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSI converter
// Holds the CORDIC word widths, the arctangent table and the stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int ACC_BITS     = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 28;
    localparam int HUE_W        = 12;
    localparam int SAT_W        = 13;
    localparam int SUM_W        = 10;

    localparam logic signed [XY_W-1:0] SQRT3_Q14 = 28'sd28378;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ACC_BITS-1:0]    acc;
    } t_cordic;

    // atan(2^-i) in units of 2^-20 turn, rounded to nearest
    function automatic logic [ACC_BITS-1:0] atan_turn(input int unsigned idx);
        logic [ACC_BITS-1:0] v;
        case (idx)
            0:       v = 20'd131072;
            1:       v = 20'd77376;
            2:       v = 20'd40884;
            3:       v = 20'd20753;
            4:       v = 20'd10417;
            5:       v = 20'd5213;
            6:       v = 20'd2607;
            7:       v = 20'd1304;
            8:       v = 20'd652;
            9:       v = 20'd326;
            10:      v = 20'd163;
            11:      v = 20'd81;
            12:      v = 20'd41;
            13:      v = 20'd20;
            14:      v = 20'd10;
            15:      v = 20'd5;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/rhc_cordic_stage.sv
// ----------------------------------------------------------------------------
// rhc_cordic_stage: one CORDIC vectoring rotation
// Rotates the vector toward the x axis by atan(2^-STEP) and books the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_cordic_stage #(
    parameter int STEP = 0
) (
    input  var rhc_pkg::t_cordic i_cd,
    output var rhc_pkg::t_cordic o_cd
);
    import rhc_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = i_cd.x >>> STEP;
    assign ys = i_cd.y >>> STEP;

    always_comb begin
        if (i_cd.y > 0) begin
            o_cd.x   = i_cd.x + ys;
            o_cd.y   = i_cd.y - xs;
            o_cd.acc = i_cd.acc + atan_turn(STEP);
        end else begin
            o_cd.x   = i_cd.x - ys;
            o_cd.y   = i_cd.y + xs;
            o_cd.acc = i_cd.acc - atan_turn(STEP);
        end
    end

endmodule

`default_nettype wire

>>> sv/rhc_div_stage.sv
// ----------------------------------------------------------------------------
// rhc_div_stage: one restoring division step
// Decides one quotient bit by comparing the remainder with the shifted divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_stage #(
    parameter int DW  = 23,
    parameter int QB  = 13,
    parameter int BIT = 0
) (
    input  var logic [DW-1:0] i_rem,
    input  var logic [10:0]   i_div,
    input  var logic [QB-1:0] i_quo,
    output var logic [DW-1:0] o_rem,
    output var logic [QB-1:0] o_quo
);
    logic [DW-1:0] vs;

    assign vs = DW'(i_div) << BIT;

    always_comb begin
        o_quo = i_quo;
        if (i_rem >= vs) begin
            o_rem      = i_rem - vs;
            o_quo[BIT] = 1'b1;
        end else begin
            o_rem = i_rem;
        end
    end

endmodule

`default_nettype wire

>>> sv/rgb_to_hsi_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_convert: pipelined RGB to HSI pixel converter
// Hue by a 16-step CORDIC vectoring pipeline, saturation by a pipelined
// restoring divider running alongside, intensity as the plain channel sum.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | fields
//  --------+--------------------+------------------------------------------
//  input   | i_valid / o_stall  | i_red, i_green, i_blue
//  output  | o_valid / i_stall  | o_hue_angle, o_saturation, o_intensity_sum
//
//  One word enters per cycle while no output word is held off; the pipeline
//  is one setup stage, one stage per CORDIC rotation or quotient bit, and the
//  output register. The CORDIC chain sets the depth at the default widths.
//  Reset clears all valid bits; payload registers are not reset.
//  A stall at the output freezes the whole pipeline while a word waits;
//  bubbles are not squeezed out, but the input is taken whenever the output is empty.
//
`default_nettype none

module rgb_to_hsi_convert #(
    parameter int HUE_BITS = 12,
    parameter int SAT_BITS = 12
) (
    input  var logic                      i_clk,
    input  var logic                      i_rst_n,
    input  var logic                      i_valid,
    output var logic                      o_stall,
    input  var logic [7:0]                i_red,
    input  var logic [7:0]                i_green,
    input  var logic [7:0]                i_blue,
    output var logic                      o_valid,
    input  var logic                      i_stall,
    output var logic [rhc_pkg::HUE_W-1:0] o_hue_angle,
    output var logic [rhc_pkg::SAT_W-1:0] o_saturation,
    output var logic [rhc_pkg::SUM_W-1:0] o_intensity_sum
);
    import rhc_pkg::*;

    // quotient bits, dividend width, step stage count
    localparam int QB   = SAT_BITS + 1;
    localparam int DW   = SAT_BITS + 11;
    localparam int L    = (CORDIC_STEPS > QB) ? CORDIC_STEPS : QB;
    localparam int HSH  = ACC_BITS - HUE_BITS;
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (HSH - 1);

    // advance the whole pipeline unless a finished word is held off
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // ---------------- setup stage ----------------
    logic [SUM_W-1:0]       n_sum;
    logic [7:0]             n_min;
    logic                   n_eq;
    logic signed [10:0]     d2;
    logic signed [8:0]      dgb;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    t_cordic                n_cd0;
    logic [SUM_W-1:0]       sdiff;
    logic [DW-1:0]          n_rem0;

    always_comb begin
        n_sum = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
        n_min = i_red;
        if (i_green < n_min) n_min = i_green;
        if (i_blue < n_min) n_min = i_blue;
        n_eq  = (i_red == i_green) && (i_green == i_blue);
        d2    = 11'($signed({3'b000, i_red}) <<< 1) - 11'($signed({3'b000, i_green}))
              - 11'($signed({3'b000, i_blue}));
        dgb   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        x0    = XY_W'(d2) <<< 14;
        y0    = XY_W'(dgb) * SQRT3_Q14;
        // fold the left half plane onto the right, starting half a turn on
        if (x0 < 0) begin
            n_cd0.x   = -x0;
            n_cd0.y   = -y0;
            n_cd0.acc = ACC_BITS'(1) << (ACC_BITS - 1);
        end else begin
            n_cd0.x   = x0;
            n_cd0.y   = y0;
            n_cd0.acc = '0;
        end
        sdiff  = n_sum - SUM_W'(10'(n_min) * 10'd3);
        n_rem0 = (DW'(sdiff) << (SAT_BITS + 1)) + DW'(n_sum);
    end

    // ---------------- pipeline registers ----------------
    logic             r_valid [0:L];
    t_cordic          r_cd    [0:L];
    logic [DW-1:0]    r_rem   [0:L];
    logic [QB-1:0]    r_quo   [0:L];
    logic [10:0]      r_div   [0:L];
    logic [SUM_W-1:0] r_sum   [0:L];
    logic             r_eq    [0:L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (adv) begin
            r_valid[0] <= i_valid;
        end
        if (adv) begin
            r_cd[0]  <= n_cd0;
            r_rem[0] <= n_rem0;
            r_quo[0] <= '0;
            r_div[0] <= {n_sum, 1'b0};
            r_sum[0] <= n_sum;
            r_eq[0]  <= n_eq;
        end
    end

    // ---------------- step stages ----------------
    for (genvar k = 0; k < L; k++) begin : g_step
        t_cordic       n_cd;
        logic [DW-1:0] n_rem;
        logic [QB-1:0] n_quo;

        if (k < CORDIC_STEPS) begin : g_rot
            rhc_cordic_stage #(.STEP(k)) u_rot (
                .i_cd (r_cd[k]),
                .o_cd (n_cd)
            );
        end else begin : g_rot_hold
            assign n_cd = r_cd[k];
        end

        if (k < QB) begin : g_dbit
            rhc_div_stage #(.DW(DW), .QB(QB), .BIT(QB - 1 - k)) u_dbit (
                .i_rem (r_rem[k]),
                .i_div (r_div[k]),
                .i_quo (r_quo[k]),
                .o_rem (n_rem),
                .o_quo (n_quo)
            );
        end else begin : g_dbit_hold
            assign n_rem = r_rem[k];
            assign n_quo = r_quo[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (adv) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (adv) begin
                r_cd[k+1]  <= n_cd;
                r_rem[k+1] <= n_rem;
                r_quo[k+1] <= n_quo;
                r_div[k+1] <= r_div[k];
                r_sum[k+1] <= r_sum[k];
                r_eq[k+1]  <= r_eq[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic [ACC_BITS-1:0] acc_rnd;
    logic [HUE_BITS-1:0] hue;
    logic                r_out_valid;
    logic [HUE_W-1:0]    r_hue;
    logic [SAT_W-1:0]    r_sat;
    logic [SUM_W-1:0]    r_isum;

    // round half up, wrapping a near-full turn to zero
    assign acc_rnd = r_cd[L].acc + HALF;
    assign hue     = acc_rnd[ACC_BITS-1 -: HUE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_valid[L];
        end
        if (adv) begin
            r_hue  <= r_eq[L] ? '0 : HUE_W'(hue);
            r_sat  <= r_eq[L] ? '0 : SAT_W'(r_quo[L]);
            r_isum <= r_sum[L];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hue_angle     = r_hue;
    assign o_saturation    = r_sat;
    assign o_intensity_sum = r_isum;

endmodule

`default_nettype wire

>>> sv/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks for the RGB to HSI converter
// Watches the handshakes and result ranges seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_checker (
    input var logic                      i_clk,
    input var logic                      i_rst_n,
    input var logic                      o_stall,
    input var logic                      o_valid,
    input var logic                      i_stall,
    input var logic [rhc_pkg::HUE_W-1:0] o_hue_angle,
    input var logic [rhc_pkg::SAT_W-1:0] o_saturation,
    input var logic [rhc_pkg::SUM_W-1:0] o_intensity_sum
);
    // a held word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue_angle)
            && $stable(o_saturation) && $stable(o_intensity_sum))
        else $error("held output word changed");

    // the input is only held off by a waiting output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no waiting word");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_intensity_sum <= 10'd765)
        else $error("intensity sum out of range");

    // full saturation only when the sum is nonzero; zero sum means gray
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_intensity_sum == 10'd0 |-> o_saturation == 13'd0
            && o_hue_angle == 12'd0)
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsi_convert rhc_checker u_rhc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_hue_angle     (o_hue_angle),
    .o_saturation    (o_saturation),
    .o_intensity_sum (o_intensity_sum)
);

`default_nettype wire

>>> dv/rgb_to_hsi_convert_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_convert_tb: self-checking bench for the RGB to HSI converter
// Drives directed and random pixels with random idle and stall bursts and
// compares every output word against a bit-exact CORDIC and divider model.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected-word store: computes HSI for each accepted pixel, checks outputs.
class hsi_scoreboard;
    typedef struct {
        logic [rhc_pkg::HUE_W-1:0] hue;
        logic [rhc_pkg::SAT_W-1:0] sat;
        logic [rhc_pkg::SUM_W-1:0] sum;
    } t_hsi;

    t_hsi pending_hsi[$];
    int   n_errors;
    int   n_checked;

    function new();
        n_errors  = 0;
        n_checked = 0;
    endfunction

    // floor shift for signed values
    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function logic [rhc_pkg::HUE_W-1:0] cordic_hue(longint x, longint y);
        logic [rhc_pkg::ACC_BITS-1:0] acc;
        longint xs, ys;
        logic [rhc_pkg::ACC_BITS:0] rnd;
        logic [rhc_pkg::ACC_BITS:0] half_lsb;
        acc = '0;
        half_lsb = '0;
        half_lsb[rhc_pkg::ACC_BITS - 12 - 1] = 1'b1;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc[rhc_pkg::ACC_BITS - 1] = 1'b1;
        end
        for (int i = 0; i < rhc_pkg::CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + rhc_pkg::atan_turn(i);
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - rhc_pkg::atan_turn(i);
            end
        end
        rnd = {1'b0, acc} + half_lsb;
        return rnd[rhc_pkg::ACC_BITS-1 -: 12];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_hsi   e;
        longint lr, lg, lb, s, mn, num;
        lr = longint'(r); lg = longint'(g); lb = longint'(b);
        s = lr + lg + lb;
        e.hue = '0;
        e.sat = '0;
        if (!(lr == lg && lg == lb)) begin
            mn = lr;
            if (lg < mn) mn = lg;
            if (lb < mn) mn = lb;
            e.hue = cordic_hue((2 * lr - lg - lb) * 16384, (lg - lb) * 28378);
            num = (s - 3 * mn) * 4096;
            e.sat = rhc_pkg::SAT_W'((2 * num + s) / (2 * s));
        end
        e.sum = rhc_pkg::SUM_W'(s);
        pending_hsi.push_back(e);
    endfunction

    function void check_word(logic [rhc_pkg::HUE_W-1:0] h, logic [rhc_pkg::SAT_W-1:0] sa,
                             logic [rhc_pkg::SUM_W-1:0] su);
        t_hsi e;
        if (pending_hsi.size() == 0) begin
            $display("%0t: unexpected word hue=%0d sat=%0d sum=%0d", $time, h, sa, su);
            n_errors++;
            return;
        end
        e = pending_hsi.pop_front();
        n_checked++;
        if (h !== e.hue) begin
            $display("%0t: hue expected %0d actual %0d", $time, e.hue, h);
            n_errors++;
        end
        if (sa !== e.sat) begin
            $display("%0t: saturation expected %0d actual %0d", $time, e.sat, sa);
            n_errors++;
        end
        if (su !== e.sum) begin
            $display("%0t: intensity sum expected %0d actual %0d", $time, e.sum, su);
            n_errors++;
        end
    endfunction
endclass

module rgb_to_hsi_convert_tb;

    localparam int LATENCY = 18;
    localparam int N_RANDOM = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic o_stall, o_valid;
    logic [rhc_pkg::HUE_W-1:0] o_hue_angle;
    logic [rhc_pkg::SAT_W-1:0] o_saturation;
    logic [rhc_pkg::SUM_W-1:0] o_intensity_sum;

    hsi_scoreboard hsi_sb = new();
    bit quiet_tail = 1'b0;  // no idling in the last part of the run
    bit hold_off   = 1'b0;  // request a long receiver stall
    bit hold_done  = 1'b0;
    int n_sent = 0;

    always #5 i_clk = ~i_clk;

    rgb_to_hsi_convert DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_red, .i_green, .i_blue,
        .o_valid, .i_stall, .o_hue_angle, .o_saturation, .o_intensity_sum
    );

    // Score accepted words on both channels at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                hsi_sb.note_pixel(i_red, i_green, i_blue);
            end
            if (o_valid && !i_stall) begin
                hsi_sb.check_word(o_hue_angle, o_saturation, o_intensity_sum);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off so the pipeline
    // fills and pushes back on the sender.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !hold_done) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_done = 1'b1;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one pixel and hold it until taken; idle gaps come before it.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin g = r; b = r; end                  // gray
            1: begin g = r; end                          // two equal channels
            2: begin b = g; end                          // hue on the axis
            3: begin r = 8'($urandom_range(0, 3)); g = 8'($urandom_range(0, 3));
                     b = 8'($urandom_range(0, 3)); end   // dark pixels
            4: begin r = 8'd255; g = 8'd255 - 8'($urandom_range(0, 2));
                     b = r - 8'($urandom_range(0, 2)); end   // near white
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, grays, primaries, secondaries, near full turn.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd2);
        send_pixel(8'd254, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd170, 8'd85,  8'd85);
        send_pixel(8'd0,   8'd128, 8'd127);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd1,   8'd2,   8'd3);
        send_pixel(8'd254, 8'd253, 8'd255);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 100) hold_off = 1'b1;
            if (k == N_RANDOM - 60) quiet_tail = 1'b1;
            send_random_pixel();
        end
        i_valid <= 1'b0;

        waited = 0;
        while (hsi_sb.pending_hsi.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (hsi_sb.pending_hsi.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time,
                     hsi_sb.pending_hsi.size());
            hsi_sb.n_errors++;
        end

        $display("Sent %0d pixels (grays, primaries, dark and random), checked %0d words,",
                 n_sent, hsi_sb.n_checked);
        $display("with idle/stall bursts and one long output hold-off; errors: %0d",
                 hsi_sb.n_errors);
        if (hsi_sb.n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
